// ----- src/dpep_pkg.sv -----
// dpep_pkg: shared types, register codes and reset constants for the
// dark pixel extreme points block; no dependencies
package dpep_pkg;

	localparam int DIM_W   = 13;
	localparam int COORD_W = 12;
	localparam int CHAN_W  = 8;
	localparam int CNT_W   = 3;
	localparam int SHAPE_W = 2;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH    = 13'd640;
	localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT   = 13'd480;
	localparam logic [CHAN_W-1:0] RST_DARK_THRESHOLD = 8'd60;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CHAN_W-1:0]  chan_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} point_t;

	typedef struct packed {
		logic [DIM_W-1:0]  frame_width;
		logic [DIM_W-1:0]  frame_height;
		chan_t             dark_threshold;
	} cfg_t;

	typedef struct packed {
		point_t              top;
		point_t              bottom;
		point_t              left;
		point_t              right;
		logic [CNT_W-1:0]    distinct_points;
		logic [SHAPE_W-1:0]  shape_class;
	} result_t;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH    = 2'd0,
		REG_FRAME_HEIGHT   = 2'd1,
		REG_DARK_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef enum logic [SHAPE_W-1:0] {
		SHAPE_UNKNOWN  = 2'd0,
		SHAPE_TRIANGLE = 2'd1,
		SHAPE_ELLIPSE  = 2'd2
	} shape_t;

endpackage

// ----- src/dpep_pix_if.sv -----
// dpep_pix_if: pixel word channel (valid, ready, three color channels)
// depends on dpep_pkg
interface dpep_pix_if import dpep_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t blue;
	chan_t green;
	chan_t red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

// ----- src/dpep_pts_if.sv -----
// dpep_pts_if: extreme points result word channel
// depends on dpep_pkg
interface dpep_pts_if import dpep_pkg::*; ();
	logic                valid;
	logic                ready;
	coord_t              top_row;
	coord_t              top_col;
	coord_t              bottom_row;
	coord_t              bottom_col;
	coord_t              left_row;
	coord_t              left_col;
	coord_t              right_row;
	coord_t              right_col;
	logic [CNT_W-1:0]    distinct_points;
	logic [SHAPE_W-1:0]  shape_class;

	modport source (
		output valid, output top_row, output top_col, output bottom_row, output bottom_col,
		output left_row, output left_col, output right_row, output right_col,
		output distinct_points, output shape_class, input ready
	);
	modport sink (
		input valid, input top_row, input top_col, input bottom_row, input bottom_col,
		input left_row, input left_col, input right_row, input right_col,
		input distinct_points, input shape_class, output ready
	);
endinterface

// ----- src/dpep_pixel_stage.sv -----
// dpep_pixel_stage: input register with dark pixel classification
// depends on dpep_pkg and dpep_pix_if
module dpep_pixel_stage import dpep_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	dpep_pix_if.sink        pix,
	input  chan_t           threshold,
	input  logic            advance,
	output logic            valid,
	output logic            dark
);

	logic valid_s1;
	logic dark_s1;
	logic take;
	logic dark_in;

	assign pix.ready = !valid_s1 || advance;
	assign take      = pix.valid && pix.ready;
	assign dark_in   = (pix.blue < threshold) || (pix.green < threshold) ||
	                   (pix.red < threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dark_s1 <= dark_in;
		end
	end

	assign valid = valid_s1;
	assign dark  = dark_s1;

endmodule

// ----- src/dpep_tracker.sv -----
// dpep_tracker: raster position counters, extreme point tracking and
// end of frame result; depends on dpep_pkg
module dpep_tracker import dpep_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     advance,
	input  logic     dark,
	output logic     frame_end,
	output result_t  result
);

	localparam int LIM = (MAX_DIM > 4096) ? 4096 : ((MAX_DIM < 1) ? 1 : MAX_DIM);
	localparam logic [DIM_W-1:0] LIM_D = DIM_W'(LIM);

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (v > LIM_D) r = LIM_D;
		else r = v;
		return r;
	endfunction

	coord_t row_q, col_q;
	logic   seen_q;
	point_t top_q, bottom_q, left_q, right_q;

	point_t here;
	point_t top_n, bottom_n, left_n, right_n;
	logic   seen_n;
	logic   row_end;
	logic [CNT_W-1:0] cnt;

	always_comb begin
		here    = '{row: row_q, col: col_q};
		row_end = ({1'b0, col_q} + DIM_W'(1)) >= eff_dim(cfg.frame_width);
		frame_end = row_end && (({1'b0, row_q} + DIM_W'(1)) >= eff_dim(cfg.frame_height));

		top_n    = top_q;
		bottom_n = bottom_q;
		left_n   = left_q;
		right_n  = right_q;
		seen_n   = seen_q || dark;
		if (dark) begin
			if (!seen_q) begin
				top_n    = here;
				bottom_n = here;
				left_n   = here;
				right_n  = here;
			end else begin
				if (row_q > bottom_q.row) bottom_n = here;
				if (col_q < left_q.col)   left_n   = here;
				if (col_q > right_q.col)  right_n  = here;
			end
		end

		// count of distinct points among top, bottom, left, right
		cnt = CNT_W'(1)
		    + CNT_W'(bottom_n != top_n)
		    + CNT_W'((left_n != top_n) && (left_n != bottom_n))
		    + CNT_W'((right_n != top_n) && (right_n != bottom_n) && (right_n != left_n));
		if (!seen_n) cnt = '0;

		result.top             = top_n;
		result.bottom          = bottom_n;
		result.left            = left_n;
		result.right           = right_n;
		result.distinct_points = cnt;
		case (cnt)
			3'd3:    result.shape_class = SHAPE_TRIANGLE;
			3'd4:    result.shape_class = SHAPE_ELLIPSE;
			default: result.shape_class = SHAPE_UNKNOWN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			seen_q   <= 1'b0;
			top_q    <= '0;
			bottom_q <= '0;
			left_q   <= '0;
			right_q  <= '0;
		end else if (advance) begin
			if (frame_end) begin
				row_q    <= '0;
				col_q    <= '0;
				seen_q   <= 1'b0;
				top_q    <= '0;
				bottom_q <= '0;
				left_q   <= '0;
				right_q  <= '0;
			end else begin
				seen_q   <= seen_n;
				top_q    <= top_n;
				bottom_q <= bottom_n;
				left_q   <= left_n;
				right_q  <= right_n;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + COORD_W'(1);
				end else begin
					col_q <= col_q + COORD_W'(1);
				end
			end
		end
	end

endmodule

// ----- src/dark_pixel_extreme_points_core.sv -----
// result path: a frame's last pixel word passes the input register, then its result word
//   is loaded into the result register once that slot is free or being drained
// throughput: one pixel word per cycle; the only stall is a frame's last pixel
//   meeting a result word that has not yet been taken
// reset (arst_n low, asynchronous): registers return to 640 x 480, threshold 60,
//   counters and tracked points clear, no word is held
// depends on dpep_pkg, dpep_pix_if, dpep_pts_if, dpep_pixel_stage, dpep_tracker
module dark_pixel_extreme_points_core import dpep_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	// apb style configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	// streams
	dpep_pix_if.sink           pix,
	dpep_pts_if.source         pts
);

	// configuration registers
	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= RST_FRAME_WIDTH;
			cfg_q.frame_height   <= RST_FRAME_HEIGHT;
			cfg_q.dark_threshold <= RST_DARK_THRESHOLD;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRAME_WIDTH:    cfg_q.frame_width    <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT:   cfg_q.frame_height   <= pwdata[DIM_W-1:0];
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back, the unused register index reads zero
	always_comb begin
		case (reg_idx)
			REG_FRAME_WIDTH:    prdata = DATA_W'(cfg_q.frame_width);
			REG_FRAME_HEIGHT:   prdata = DATA_W'(cfg_q.frame_height);
			REG_DARK_THRESHOLD: prdata = DATA_W'(cfg_q.dark_threshold);
			default:            prdata = '0;
		endcase
	end

	// stage 1: accepted pixel word and its dark flag
	logic valid_s1;
	logic dark_s1;
	logic advance;
	logic frame_end;
	result_t result;

	dpep_pixel_stage u_pixel_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.threshold (cfg_q.dark_threshold),
		.advance   (advance),
		.valid     (valid_s1),
		.dark      (dark_s1)
	);

	// stage 2: position and point tracking, the result is formed from the
	// updated points in the same cycle as the frame's last pixel
	dpep_tracker #(
		.MAX_DIM (MAX_DIM)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.advance   (advance),
		.dark      (dark_s1),
		.frame_end (frame_end),
		.result    (result)
	);

	// output register; a pixel that closes a frame waits only when the slot
	// is still full and not being drained this cycle
	logic    out_valid_q;
	result_t result_q;

	assign advance = valid_s1 && (!frame_end || !out_valid_q || pts.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (pts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_end) begin
			result_q <= result;
		end
	end

	assign pts.valid           = out_valid_q;
	assign pts.top_row         = result_q.top.row;
	assign pts.top_col         = result_q.top.col;
	assign pts.bottom_row      = result_q.bottom.row;
	assign pts.bottom_col      = result_q.bottom.col;
	assign pts.left_row        = result_q.left.row;
	assign pts.left_col        = result_q.left.col;
	assign pts.right_row       = result_q.right.row;
	assign pts.right_col       = result_q.right.col;
	assign pts.distinct_points = result_q.distinct_points;
	assign pts.shape_class     = result_q.shape_class;

	// a stalled stage 1 word must block new input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !pix.ready)
		else $error("input accepted while stage 1 is stalled");

	// a held result is never overwritten by a new frame
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pts.ready) |-> !(advance && frame_end))
		else $error("pending result overwritten");

	// shape class follows the distinct point count
	a_shape_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (((result_q.shape_class == SHAPE_ELLIPSE) ==
		                  (result_q.distinct_points == 3'd4)) &&
		                 ((result_q.shape_class == SHAPE_TRIANGLE) ==
		                  (result_q.distinct_points == 3'd3))))
		else $error("shape class does not match distinct point count");

	// an empty frame reports all points at the origin
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (result_q.distinct_points == 3'd0)) |->
		((result_q.top == '0) && (result_q.bottom == '0) &&
		 (result_q.left == '0) && (result_q.right == '0)))
		else $error("empty frame with nonzero points");

endmodule

// ----- sim/dpep_frame_checker.sv -----
`timescale 1ns / 100ps
// dpep_frame_checker: watches the pixel, result and register ports, tracks the
// extreme points of each frame and compares every result word field by field
// depends on dpep_pkg, dpep_pix_if, dpep_pts_if
module dpep_frame_checker import dpep_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	dpep_pix_if                pix,
	dpep_pts_if                pts,
	output int                 errors,
	output int                 outstanding,
	output int                 frames_checked
);

	cfg_t    cfg;
	coord_t  row_pos;
	coord_t  col_pos;
	logic    dark_seen;
	point_t  top_pt;
	point_t  bottom_pt;
	point_t  left_pt;
	point_t  right_pt;
	result_t pending_frames[$];

	function automatic int clamp_dim(input logic [DIM_W-1:0] v);
		int lim;
		lim = (MAX_DIM < 4096) ? MAX_DIM : 4096;
		if (lim < 1) lim = 1;
		if (v == 0) return 1;
		if (int'(v) > lim) return lim;
		return int'(v);
	endfunction

	task automatic clear_frame();
		row_pos   = '0;
		col_pos   = '0;
		dark_seen = 1'b0;
		top_pt    = '0;
		bottom_pt = '0;
		left_pt   = '0;
		right_pt  = '0;
	endtask

	// one pixel word: update points, advance position, queue a result at frame end
	task automatic track_pixel(input chan_t b, input chan_t g, input chan_t r);
		int      w;
		int      h;
		bit      dark;
		bit      row_end;
		bit      frame_end;
		bit      dup;
		int      n;
		point_t  here;
		point_t  corner[4];
		result_t res;
		dark = (b < cfg.dark_threshold) || (g < cfg.dark_threshold) ||
			(r < cfg.dark_threshold);
		w = clamp_dim(cfg.frame_width);
		h = clamp_dim(cfg.frame_height);
		row_end = (int'(col_pos) + 1) >= w;
		frame_end = row_end && ((int'(row_pos) + 1) >= h);
		here = {row_pos, col_pos};
		if (dark) begin
			if (!dark_seen) begin
				top_pt    = here;
				bottom_pt = here;
				left_pt   = here;
				right_pt  = here;
				dark_seen = 1'b1;
			end else begin
				if (row_pos > bottom_pt.row) bottom_pt = here;
				if (col_pos < left_pt.col) left_pt = here;
				if (col_pos > right_pt.col) right_pt = here;
			end
		end
		if (!frame_end) begin
			if (row_end) begin
				col_pos = '0;
				row_pos = row_pos + 1'b1;
			end else begin
				col_pos = col_pos + 1'b1;
			end
		end else begin
			corner = '{top_pt, bottom_pt, left_pt, right_pt};
			n = 0;
			if (dark_seen) begin
				for (int i = 0; i < 4; i++) begin
					dup = 1'b0;
					for (int j = 0; j < i; j++) begin
						if (corner[j] == corner[i]) dup = 1'b1;
					end
					if (!dup) n++;
				end
			end else begin
				corner = '{default: '0};
			end
			res.top             = corner[0];
			res.bottom          = corner[1];
			res.left            = corner[2];
			res.right           = corner[3];
			res.distinct_points = n[CNT_W-1:0];
			res.shape_class     = (n == 3) ? SHAPE_TRIANGLE :
				(n == 4) ? SHAPE_ELLIPSE : SHAPE_UNKNOWN;
			pending_frames.insert(pending_frames.size(), res);
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endtask

	task automatic check_result();
		result_t exp_r;
		if (pending_frames.size() == 0) begin
			$error("result word with no frame pending");
			errors++;
		end else begin
			exp_r = pending_frames.pop_front();
			check_field("top_row", 32'(exp_r.top.row), 32'(pts.top_row));
			check_field("top_col", 32'(exp_r.top.col), 32'(pts.top_col));
			check_field("bottom_row", 32'(exp_r.bottom.row), 32'(pts.bottom_row));
			check_field("bottom_col", 32'(exp_r.bottom.col), 32'(pts.bottom_col));
			check_field("left_row", 32'(exp_r.left.row), 32'(pts.left_row));
			check_field("left_col", 32'(exp_r.left.col), 32'(pts.left_col));
			check_field("right_row", 32'(exp_r.right.row), 32'(pts.right_row));
			check_field("right_col", 32'(exp_r.right.col), 32'(pts.right_col));
			check_field("distinct_points", 32'(exp_r.distinct_points),
				32'(pts.distinct_points));
			check_field("shape_class", 32'(exp_r.shape_class), 32'(pts.shape_class));
			frames_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.frame_width    = RST_FRAME_WIDTH;
			cfg.frame_height   = RST_FRAME_HEIGHT;
			cfg.dark_threshold = RST_DARK_THRESHOLD;
			clear_frame();
			pending_frames.delete();
			errors         = 0;
			outstanding    = 0;
			frames_checked = 0;
		end else begin
			if (pts.valid && pts.ready) check_result();
			if (pix.valid && pix.ready) track_pixel(pix.blue, pix.green, pix.red);
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_FRAME_WIDTH:    cfg.frame_width    = pwdata[DIM_W-1:0];
					REG_FRAME_HEIGHT:   cfg.frame_height   = pwdata[DIM_W-1:0];
					REG_DARK_THRESHOLD: cfg.dark_threshold = pwdata[CHAN_W-1:0];
					default: ;
				endcase
			end
			outstanding = pending_frames.size();
		end
	end

endmodule

// ----- sim/dark_pixel_extreme_points_core_test.sv -----
`timescale 1ns / 100ps
// dark_pixel_extreme_points_core_test: drives frames and register settings into
// the extreme points core and reports the verdict of dpep_frame_checker
// depends on dpep_pkg, dpep_pix_if, dpep_pts_if, dpep_frame_checker, the core
module dark_pixel_extreme_points_core_test;
	import dpep_pkg::*;

	localparam int MAX_DIM        = 4096;
	localparam int WATCHDOG_LIMIT = 2000;  // idle cycles before giving up
	localparam int RANDOM_WORDS   = 1000;  // pixel words in the random part
	localparam int RANDOM_FRAMES  = 60;    // keep going until this many frames too

	// how the dark pixels of a frame are laid out
	typedef enum int {
		FRAME_MASK,    // explicit bit mask, row major, small frames only
		FRAME_NOISE,   // every channel fully random
		FRAME_SPARSE,  // dark pixels scattered at a random density
		FRAME_BLOB,    // diamond around a random center, usually four points
		FRAME_WEDGE    // right triangle growing down and right, three points
	} frame_kind_t;

	// receiver stall patterns
	typedef enum int {
		RX_ALWAYS,
		RX_PERIODIC,
		RX_RANDOM
	} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	dpep_pix_if pix ();
	dpep_pts_if pts ();

	int errors;
	int outstanding;
	int frames_checked;

	// stimulus bookkeeping
	int                 burst_left = 0;
	int                 pixels_sent = 0;
	int                 frames_sent = 0;
	int                 settings_used = 0;
	int                 quiet_cycles = 0;
	logic [DIM_W-1:0]   cur_w;
	logic [DIM_W-1:0]   cur_h;
	chan_t              cur_thr;

	dark_pixel_extreme_points_core #(
		.MAX_DIM (MAX_DIM)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix),
		.pts     (pts)
	);

	// checker sits beside the block and only watches
	dpep_frame_checker #(
		.MAX_DIM (MAX_DIM)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pix            (pix),
		.pts            (pts),
		.errors         (errors),
		.outstanding    (outstanding),
		.frames_checked (frames_checked)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog: count cycles in which no word and no register access moves
	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (pts.valid && pts.ready) ||
			(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: ready changes at the falling edge, switching stall pattern
	// after a random span so stalls land on every phase of the block
	initial begin
		rx_mode_t mode;
		int       span;
		int       period;
		int       duty;
		int       phase;
		pts.ready = 1'b0;
		span = 0;
		mode = RX_ALWAYS;
		period = 1;
		duty = 1;
		phase = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				span = $urandom_range(64, 512);
				period = $urandom_range(2, 8);
				duty = $urandom_range(1, period - 1);
				phase = 0;
			end
			span--;
			case (mode)
				RX_ALWAYS:   pts.ready = 1'b1;
				RX_PERIODIC: begin
					pts.ready = (phase < duty);
					phase = (phase + 1) % period;
				end
				default:     pts.ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// effective frame size as the block sees it: zero means one, big values clip
	function automatic int eff_len(input logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (int'(v) > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	// apb write, setup phase then access phase; junk above the register width must be dropped
	task automatic reg_write(input reg_idx_t idx, input int width, input int value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = ($urandom() << width) | DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// hold the sender until every result is back, then let the pipe settle
	task automatic wait_drained();
		pix.valid = 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// registers are only touched with the block idle
	task automatic set_frame(input int w, input int h, input int thr);
		wait_drained();
		reg_write(REG_FRAME_WIDTH, DIM_W, w);
		reg_write(REG_FRAME_HEIGHT, DIM_W, h);
		reg_write(REG_DARK_THRESHOLD, CHAN_W, thr);
		cur_w = w[DIM_W-1:0];
		cur_h = h[DIM_W-1:0];
		cur_thr = thr[CHAN_W-1:0];
		settings_used++;
	endtask

	// one pixel word, sender works in bursts with random gaps between them;
	// about a quarter of the bursts come with no gap at all
	task automatic send_pixel(input chan_t b, input chan_t g, input chan_t r);
		int gap;
		if (burst_left == 0) begin
			pix.valid = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		pix.blue = b;
		pix.green = g;
		pix.red = r;
		pix.valid = 1'b1;
		do @(posedge clk); while (!pix.ready);
		@(negedge clk);
		burst_left--;
		pixels_sent++;
	endtask

	// a whole frame at the current size, dark pixels laid out by kind
	task automatic send_frame(input frame_kind_t kind, input logic [63:0] mask);
		int    w;
		int    h;
		int    cr;
		int    cc;
		int    rad;
		int    dens;
		int    dr;
		int    dc;
		int    ch;
		bit    dark;
		chan_t px[3];
		w = eff_len(cur_w);
		h = eff_len(cur_h);
		cr = $urandom_range(0, h - 1);
		cc = $urandom_range(0, w - 1);
		rad = $urandom_range(0, 3);
		dens = $urandom_range(0, 30);
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				dr = (r > cr) ? r - cr : cr - r;
				dc = (c > cc) ? c - cc : cc - c;
				case (kind)
					FRAME_MASK:   dark = (r * w + c < 64) ? mask[r * w + c] : 1'b0;
					FRAME_SPARSE: dark = ($urandom_range(0, 99) < dens);
					FRAME_BLOB:   dark = (dr + dc <= rad);
					FRAME_WEDGE:  dark = (r >= cr) && (c >= cc) && (c - cc <= r - cr);
					default:      dark = 1'b0;
				endcase
				if (kind == FRAME_NOISE) begin
					foreach (px[k]) px[k] = CHAN_W'($urandom_range(0, 255));
				end else if (dark && cur_thr != 0) begin
					// one channel under the threshold is enough, others anything
					foreach (px[k]) px[k] = CHAN_W'($urandom_range(0, 255));
					ch = $urandom_range(0, 2);
					px[ch] = CHAN_W'($urandom_range(0, cur_thr - 1));
				end else begin
					foreach (px[k]) px[k] = CHAN_W'($urandom_range(cur_thr, 255));
				end
				send_pixel(px[0], px[1], px[2]);
			end
		end
		frames_sent++;
	endtask

	initial begin
		int          random_start;
		int          n_frames;
		int          pick;
		int          w;
		int          h;
		int          thr;
		frame_kind_t kind;

		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix.valid = 1'b0;
		pix.blue = '0;
		pix.green = '0;
		pix.red = '0;
		cur_w = RST_FRAME_WIDTH;
		cur_h = RST_FRAME_HEIGHT;
		cur_thr = RST_DARK_THRESHOLD;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: zero sizes act as a 1x1 frame; top threshold so only a full
		// white pixel stays light; an empty frame, then channel extremes
		set_frame(0, 0, 255);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd254, 8'd255);
		frames_sent += 3;

		// plus sign without its center in 3x3: four distinct points, ellipse
		set_frame(3, 3, 128);
		send_frame(FRAME_MASK, 64'h0aa);

		// 3 wide, 2 rows: left coincides with top, three points, triangle
		set_frame(3, 2, 100);
		send_frame(FRAME_MASK, 64'h029);

		// a single dark pixel at the last spot: all four points the same
		set_frame(2, 2, 1);
		send_frame(FRAME_MASK, 64'h008);

		// zero threshold: nothing can be dark even with black input
		set_frame(1, 1, 0);
		send_pixel(8'd0, 8'd0, 8'd0);
		frames_sent++;

		// random part: small frames under many settings
		random_start = pixels_sent;
		while ((pixels_sent - random_start) < RANDOM_WORDS || frames_sent < RANDOM_FRAMES) begin
			w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
			h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			pick = $urandom_range(0, 9);
			thr = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 254);
			set_frame(w, h, thr);
			n_frames = $urandom_range(1, 4);
			repeat (n_frames) begin
				pick = $urandom_range(0, 9);
				kind = (pick < 2) ? FRAME_NOISE :
					(pick < 5) ? FRAME_SPARSE :
					(pick < 8) ? FRAME_BLOB : FRAME_WEDGE;
				send_frame(kind, '0);
			end
		end

		// wait for the last results, then watch for stray words
		pix.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d frames and %0d pixel words over %0d register settings",
			frames_checked, pixels_sent, settings_used);
		$display("sizes from 1x1 to 8x6 pixels with zero sizes as 1x1, thresholds 0 to 255");
		if (errors == 0 && outstanding == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/dpep_pkg.sv
src/dpep_pix_if.sv
src/dpep_pts_if.sv
src/dpep_pixel_stage.sv
src/dpep_tracker.sv
src/dark_pixel_extreme_points_core.sv
sim/dpep_frame_checker.sv
sim/dark_pixel_extreme_points_core_test.sv
